### design/i2dc_pkg.sv
// Package for the 2D convolution block: widths, depths, action codes.
// No dependencies.
`timescale 1ns / 1ps
package i2dc_pkg;
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_KERNEL   = 7;
	localparam int MAX_HEIGHT   = 4096;
	localparam int HIST_DEPTH   = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;
	localparam int WEIGHT_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int HA_W         = $clog2(HIST_DEPTH);
	localparam int WA_W         = $clog2(WEIGHT_DEPTH);
	localparam int CNT_W        = 23;
	localparam int OCNT_W       = 23;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_START = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_KWIDTH  = 2'd2,
		REG_KHEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_TAP   = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;
endpackage

### design/image_2d_convolution_8s16s.sv
// 2D convolution top level: pixel ring memory, weight memory, tap sequencer.
// Depends on i2dc_pkg.
//
// Usage: configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Input transactions (action, pixel, weight_index, weight_value) are taken on
// in_valid && !in_stall. Weight loads and frame starts complete without leaving
// the idle state. A pixel or flush transaction, until the frame is complete,
// writes the ring and, when an output is due, walks the kernel taps one per
// cycle through the ring memory (one read port) and a single 8x16 multiplier.
// The result sits in an output register until taken on out_valid &&
// !out_stall; a new item is accepted while it waits, but the next result
// waits for the register to empty. Reset clears the counters and starts a
// clearing pass over all HIST_DEPTH ring entries, during which no input
// transaction is taken.
`timescale 1ns / 1ps
module image_2d_convolution_8s16s
	import i2dc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [7:0]  pixel,
	input  logic [5:0]         weight_index,
	input  logic signed [15:0] weight_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] filtered,
	output logic               last
);
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [2:0]  kw_q, kh_q;
	logic [10:0] w_c;
	logic [12:0] h_c;
	logic [2:0]  kw_c, kh_c, hb_c, wb_c;
	state_t      state_q;
	logic        clr_q;
	logic [HA_W-1:0] clr_addr_q;
	logic [CNT_W-1:0]  in_cnt_q;
	logic [OCNT_W-1:0] out_cnt_q;
	logic [HA_W-1:0] in_ptr_q;
	logic [HA_W-1:0] out_ptr_q;
	logic [23:0] total_c;
	logic [23:0] look_c;
	logic [7:0]  hist_mem [HIST_DEPTH];
	logic [15:0] wt_mem   [WEIGHT_DEPTH];
	logic [7:0]  hist_rd_q;
	logic [15:0] wt_rd_q;
	logic [2:0]  ky_q, kx_q;
	logic        tap_ok_s1, tap_vld_s1;
	logic [15:0] acc_q;
	logic        res_last_q;
	logic        accept;
	logic        frame_done;
	logic signed [14:0] off_c;
	logic signed [24:0] s_c;
	logic signed [15:0] ring_sum_c;
	logic [HA_W-1:0] tap_addr;
	logic [WA_W-1:0] widx_c;
	logic        tap_ok_c;
	logic signed [23:0] prod_c;

	always_comb begin
		w_c  = (width_q == 11'd0) ? 11'd1 : (width_q > 11'(MAX_WIDTH) ? 11'(MAX_WIDTH) : width_q);
		h_c  = (height_q == 13'd0) ? 13'd1
			: (height_q > 13'(MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_q);
		kw_c = (kw_q == 3'd0) ? 3'd1 : kw_q;
		kh_c = (kh_q == 3'd0) ? 3'd1 : kh_q;
		hb_c = kh_c >> 1;
		wb_c = kw_c >> 1;
		total_c = 24'(w_c) * 24'(h_c);
		look_c  = 24'(kh_c - 3'd1 - hb_c) * 24'(w_c) + 24'(kw_c - 3'd1 - wb_c);
	end

	assign frame_done = 24'(out_cnt_q) >= total_c;
	assign in_stall   = clr_q || (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd64;
			height_q <= 13'd64;
			kw_q     <= 3'd3;
			kh_q     <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:   width_q  <= cfg_data[10:0];
				REG_HEIGHT:  height_q <= cfg_data;
				REG_KWIDTH:  kw_q     <= cfg_data[2:0];
				REG_KHEIGHT: kh_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// tap position relative to the image start, and its ring slot
	always_comb begin
		off_c = 15'(signed'({1'b0, ky_q}) - signed'({1'b0, hb_c})) * 15'(signed'({1'b0, w_c}))
			+ 15'(signed'({1'b0, kx_q})) - 15'(signed'({1'b0, wb_c}));
		s_c = 25'(signed'({1'b0, out_cnt_q})) + 25'(off_c);
		tap_ok_c = !s_c[24] && (s_c < 25'(signed'({1'b0, in_cnt_q})));
		ring_sum_c = 16'(signed'({1'b0, out_ptr_q})) + 16'(off_c);
		if (ring_sum_c < 16'sd0)
			tap_addr = HA_W'(ring_sum_c + 16'(HIST_DEPTH));
		else if (ring_sum_c >= 16'(HIST_DEPTH))
			tap_addr = HA_W'(ring_sum_c - 16'(HIST_DEPTH));
		else
			tap_addr = HA_W'(ring_sum_c);
		widx_c = WA_W'(ky_q) * WA_W'(kw_c) + WA_W'(kx_q);
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			hist_mem[clr_addr_q] <= 8'd0;
		else if (accept && !frame_done && (action == ACT_PIXEL || action == ACT_FLUSH))
			hist_mem[in_ptr_q] <= (action == ACT_PIXEL) ? pixel : 8'd0;
		if (state_q == ST_TAP)
			hist_rd_q <= hist_mem[tap_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_LOAD && 32'(weight_index) < WEIGHT_DEPTH)
			wt_mem[WA_W'(weight_index)] <= weight_value;
		if (state_q == ST_TAP)
			wt_rd_q <= wt_mem[widx_c];
	end

	assign prod_c = $signed(hist_rd_q) * $signed(wt_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			in_ptr_q   <= '0;
			out_ptr_q  <= '0;
			ky_q       <= '0;
			kx_q       <= '0;
			tap_vld_s1 <= 1'b0;
			tap_ok_s1  <= 1'b0;
			acc_q      <= '0;
			out_valid  <= 1'b0;
			res_last_q <= 1'b0;
			filtered   <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (32'(clr_addr_q) == HIST_DEPTH - 1)
					clr_q <= 1'b0;
			end
			if (state_q == ST_OUT && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_START) begin
							in_cnt_q  <= '0;
							out_cnt_q <= '0;
							in_ptr_q  <= '0;
							out_ptr_q <= '0;
						end else if ((action == ACT_PIXEL || action == ACT_FLUSH)
							&& !frame_done) begin
							in_cnt_q <= in_cnt_q + 1'b1;
							in_ptr_q <= (32'(in_ptr_q) == HIST_DEPTH - 1) ? '0 : in_ptr_q + 1'b1;
							state_q  <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					// in_cnt_q is n; emit when n-1 >= out_cnt + look
					if (25'(in_cnt_q) - 25'd1 >= 25'(out_cnt_q) + 25'(look_c)) begin
						ky_q       <= '0;
						kx_q       <= '0;
						acc_q      <= '0;
						tap_vld_s1 <= 1'b0;
						state_q    <= ST_TAP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_TAP: begin
					if (tap_vld_s1 && tap_ok_s1)
						acc_q <= acc_q + 16'(prod_c);
					tap_vld_s1 <= 1'b1;
					tap_ok_s1  <= tap_ok_c;
					if (kx_q == kw_c - 3'd1) begin
						kx_q <= '0;
						ky_q <= ky_q + 3'd1;
						if (ky_q == kh_c - 3'd1)
							state_q <= ST_OUT;
					end else begin
						kx_q <= kx_q + 3'd1;
					end
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						filtered   <= (tap_ok_s1) ? acc_q + 16'(prod_c) : acc_q;
						res_last_q <= 24'(out_cnt_q) == total_c - 24'd1;
						out_cnt_q  <= out_cnt_q + 1'b1;
						out_ptr_q  <= (32'(out_ptr_q) == HIST_DEPTH - 1) ? '0 : out_ptr_q + 1'b1;
						tap_vld_s1 <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign last = res_last_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !accept) else $error("transaction taken during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && (!out_valid || !out_stall)) |=> out_valid)
		else $error("result not issued");
endmodule

### tb/testbench.sv
// Self-checking testbench for image_2d_convolution_8s16s: random and directed
// pixel, flush, weight and frame-start transactions checked against a predictor.
// Depends on i2dc_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
	import i2dc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [15:0] filtered;
		logic        last;
	} conv_result_t;

	class conv_scoreboard;
		bit [7:0]       ring [HIST_DEPTH];
		bit [15:0]      taps [WEIGHT_DEPTH];
		int unsigned    pixels_in, results_out;
		int unsigned    img_w, img_h, ker_w, ker_h;
		conv_result_t   due_q [$];
		int             mismatches;

		function new();
			foreach (ring[i]) ring[i] = '0;
			foreach (taps[i]) taps[i] = '0;
			pixels_in = 0;
			results_out = 0;
			img_w = 64;
			img_h = 64;
			ker_w = 3;
			ker_h = 3;
			mismatches = 0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(reg_idx_t idx, logic [12:0] d);
			case (idx)
				REG_WIDTH:   img_w = d[10:0];
				REG_HEIGHT:  img_h = d[12:0];
				REG_KWIDTH:  ker_w = d[2:0];
				REG_KHEIGHT: ker_h = d[2:0];
				default: ;
			endcase
		endfunction

		function void note_input(action_t act, logic [7:0] px, logic [5:0] wi, logic [15:0] wv);
			int unsigned w, h, kw, kh, hb, wb, total, ahead, n, p;
			longint s;
			int prod;
			logic [15:0] acc;
			conv_result_t r;
			if (act == ACT_LOAD) begin
				if (wi < WEIGHT_DEPTH) taps[wi] = wv;
				return;
			end
			if (act == ACT_START) begin
				pixels_in = 0;
				results_out = 0;
				return;
			end
			w = clamp(img_w, MAX_WIDTH);
			h = clamp(img_h, MAX_HEIGHT);
			kw = clamp(ker_w, MAX_KERNEL);
			kh = clamp(ker_h, MAX_KERNEL);
			total = w * h;
			if (results_out >= total) return;
			ring[pixels_in % HIST_DEPTH] = (act == ACT_PIXEL) ? px : 8'd0;
			pixels_in++;
			n = pixels_in;
			hb = kh >> 1;
			wb = kw >> 1;
			ahead = (kh - 1 - hb) * w + (kw - 1 - wb);
			if (longint'(n) - 1 < longint'(results_out) + ahead) return;
			p = results_out;
			acc = '0;
			for (int ky = 0; ky < kh; ky++) begin
				for (int kx = 0; kx < kw; kx++) begin
					s = longint'(p) + (longint'(ky) - hb) * w + kx - wb;
					if (s < 0 || s >= n) continue;
					prod = $signed(ring[s % HIST_DEPTH]) * $signed(taps[ky * kw + kx]);
					acc = acc + prod[15:0];
				end
			end
			r.filtered = acc;
			r.last = (p == total - 1);
			due_q.push_back(r);
			results_out++;
		endfunction

		function void check_result(logic [15:0] f, logic l);
			conv_result_t e;
			if (due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: filtered=%0d last=%0d", $signed(f), l);
				return;
			end
			e = due_q.pop_front();
			if (e.filtered !== f || e.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected filtered=%0d last=%0d, got filtered=%0d last=%0d",
						$signed(e.filtered), e.last, $signed(f), l);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [12:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         action;
	logic signed [7:0]  pixel;
	logic [5:0]         weight_index;
	logic signed [15:0] weight_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] filtered;
	logic               last;

	conv_scoreboard conv_sb = new();
	bit             quiet = 1'b0;
	int unsigned    cycles = 0;

	image_2d_convolution_8s16s dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL image_2d_convolution_8s16s");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) conv_sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				conv_sb.note_input(action_t'(action), pixel, weight_index, weight_value);
			if (out_valid && !out_stall) conv_sb.check_result(filtered, last);
		end
	end

	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 9);

	task automatic send(action_t a, logic [7:0] px, logic [5:0] wi, logic [15:0] wv);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		pixel <= px;
		weight_index <= wi;
		weight_value <= wv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (conv_sb.due_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic configure(logic [12:0] w, logic [12:0] h, logic [12:0] kw, logic [12:0] kh);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= REG_KWIDTH;
		cfg_data <= kw;
		@(negedge clk);
		cfg_index <= REG_KHEIGHT;
		cfg_data <= kh;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 84) send(ACT_PIXEL, 8'($urandom), 6'($urandom), 16'($urandom));
		else if (r < 92) send(ACT_FLUSH, 8'($urandom), 6'($urandom), 16'($urandom));
		else if (r < 98) send(ACT_LOAD, 8'($urandom), 6'($urandom_range(63)), 16'($urandom));
		else send(ACT_START, 8'($urandom), 6'($urandom), 16'($urandom));
	endtask

	initial begin
		int unsigned sent, span, w, h, kw, kh;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		pixel = '0;
		weight_index = '0;
		weight_value = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// load every weight first, extremes at the first and last taps
		for (int i = 0; i < WEIGHT_DEPTH; i++)
			send(ACT_LOAD, '0, 6'(i),
				(i == 0) ? 16'h8000 : (i == 48) ? 16'h7fff : 16'($urandom));
		send(ACT_LOAD, '0, 6'd63, 16'h1234);
		send(ACT_PIXEL, 8'h80, '0, '0);
		send(ACT_PIXEL, 8'h7f, '0, '0);
		send(ACT_PIXEL, 8'h00, '0, '0);
		send(ACT_PIXEL, 8'hff, '0, '0);
		send(ACT_FLUSH, 8'h55, '0, '0);
		send(ACT_START, '0, '0, '0);

		// tiny frame: overrun into neighbouring rows, then items past completion
		configure(13'd2, 13'd2, 13'd3, 13'd3);
		for (int i = 0; i < 3; i++) send(ACT_PIXEL, 8'($urandom), '0, '0);
		for (int i = 0; i < 5; i++) send(ACT_FLUSH, '0, '0, '0);
		send(ACT_START, '0, '0, '0);

		configure(13'd0, 13'd0, 13'd0, 13'd0);
		for (int i = 0; i < 3; i++) send(ACT_PIXEL, 8'h80, '0, '0);
		send(ACT_START, '0, '0, '0);

		configure(13'h1fff, 13'd1, 13'd7, 13'd1);
		send(ACT_START, '0, '0, '0);
		for (int i = 0; i < 20; i++) random_item();

		configure(13'd1, 13'h1fff, 13'd7, 13'd7);
		send(ACT_START, '0, '0, '0);
		for (int i = 0; i < 30; i++) random_item();

		// change the kernel shape mid-frame
		configure(13'd1, 13'h1fff, 13'd5, 13'd2);
		for (int i = 0; i < 10; i++) random_item();

		sent = 0;
		while (sent < 260) begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 12);
			kw = $urandom_range(0, 7);
			kh = $urandom_range(0, 7);
			configure(13'(w), 13'(h), 13'(kw), 13'(kh));
			if ($urandom_range(3) != 0) send(ACT_START, '0, '0, '0);
			span = (kh > 1 ? kh : 1) * w / 2 + $urandom_range(10, 40);
			for (int i = 0; i < span; i++) begin
				quiet = (sent >= 150 && sent < 230);
				random_item();
				sent++;
			end
			quiet = 1'b0;
		end

		drain();
		if (conv_sb.mismatches == 0 && conv_sb.due_q.size() == 0)
			$display("PASS image_2d_convolution_8s16s");
		else
			$display("FAIL image_2d_convolution_8s16s");
		$finish;
	end
endmodule
